/* rtl/core/cloe_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the clock offset estimator.
// No dependencies; every other file of the block imports this package.
package cloe_pkg;

   localparam int STAMP_W = 63;
   localparam int RTT_W   = 63;
   localparam int OFF_W   = 64;
   localparam int TIME_W  = 64;
   localparam int CFG_W   = 7;

   localparam logic [CFG_W-1:0] BEST_COUNT_RESET = 7'd8;

   localparam logic OP_EXCHANGE = 1'b0;
   localparam logic OP_CONVERT  = 1'b1;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_CHECK  = 8'b0000_0010,
      ST_STORE  = 8'b0000_0100,
      ST_SCAN   = 8'b0000_1000,
      ST_ACCUM  = 8'b0001_0000,
      ST_NORM   = 8'b0010_0000,
      ST_DIVIDE = 8'b0100_0000,
      ST_FINISH = 8'b1000_0000
   } state_type;

endpackage

/* rtl/core/cloe_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the request and response beats.
// Depends on cloe_pkg for the field widths.
interface cloe_req_if;
   import cloe_pkg::*;
   logic               valid;
   logic               ready;
   logic               opcode;
   logic [STAMP_W-1:0] stamp_send;
   logic [STAMP_W-1:0] stamp_remote_recv;
   logic [STAMP_W-1:0] stamp_remote_send;
   logic [STAMP_W-1:0] stamp_recv;
   logic [STAMP_W-1:0] remote_time;

   modport source (output valid, opcode, stamp_send, stamp_remote_recv,
                   stamp_remote_send, stamp_recv, remote_time, input ready);
   modport sink   (input valid, opcode, stamp_send, stamp_remote_recv,
                   stamp_remote_send, stamp_recv, remote_time, output ready);
endinterface

interface cloe_rsp_if #(parameter int CNT_W = 7);
   import cloe_pkg::*;
   logic                     valid;
   logic                     ready;
   logic                     accepted;
   logic                     ready_res;
   logic [CNT_W-1:0]         sample_count;
   logic [RTT_W-1:0]         min_round_trip;
   logic signed [OFF_W-1:0]  avg_offset_half_ns;
   logic [TIME_W-1:0]        local_time;
   logic                     local_valid;

   modport source (output valid, accepted, ready_res, sample_count, min_round_trip,
                   avg_offset_half_ns, local_time, local_valid, input ready);
   modport sink   (input valid, accepted, ready_res, sample_count, min_round_trip,
                   avg_offset_half_ns, local_time, local_valid, output ready);
endinterface

/* rtl/core/clock_offset_estimator.sv */
`timescale 1ns / 1ps
// Clock offset estimator: four-timestamp exchange window with a lowest
// round trip filter. Depends on cloe_pkg and the interfaces in cloe_if.sv.
//
//   Port      Dir   Contents
//   req_bus   in    opcode, four exchange stamps, remote time to convert
//   rsp_bus   out   accepted, estimate, converted local time
//   csr_*     in    best_count write, no read-back
//
// An exchange is accepted, checked and stored in the IDLE, CHECK and STORE
// states. Then each of the K selected samples (K = min(best_count, fill), a
// best_count of 0 counting as 1) costs one scan of the window and an
// accumulate step. A bit-serial divide follows, between a setup state (NORM)
// and a result state (FINISH).
// Reset is synchronous and clears control state; the sample memories are not
// cleared. A result waiting on rsp_bus holds the block in its final state.
module clock_offset_estimator #(
   parameter int WINDOW_DEPTH = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   cloe_req_if.sink                   req_bus,
   cloe_rsp_if.source                 rsp_bus,
   input  logic                       csr_write_en,
   input  logic [cloe_pkg::CFG_W-1:0] csr_write_data
);
   import cloe_pkg::*;

   localparam int AW  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int CW  = $clog2(WINDOW_DEPTH + 1);
   localparam int SW  = OFF_W + CW + 1;
   localparam int KW  = RTT_W + AW;
   localparam int DCW = $clog2(SW + 1);
   localparam int MW  = (CW > CFG_W) ? CW : CFG_W;
   localparam logic [CW-1:0] DEPTH_C = CW'(WINDOW_DEPTH);
   localparam logic [AW:0]   DEPTH_A = (AW+1)'(WINDOW_DEPTH);

   state_type state_ff, state_in;
   logic [CFG_W-1:0]   best_count_ff, best_count_in;
   logic [STAMP_W-1:0] t0_ff, t0_in, t1_ff, t1_in, t2_ff, t2_in, t3_ff, t3_in;
   logic [STAMP_W-1:0] rt_ff, rt_in;
   logic [OFF_W-1:0]   d30_ff, d30_in, d21_ff, d21_in, a_ff, a_in, b_ff, b_in;
   logic               nz_ff, nz_in;
   logic [AW-1:0]      wp_ff, wp_in;
   logic [CW-1:0]      fill_ff, fill_in;
   logic               accepted_ff, accepted_in;
   logic               op_ff, op_in;
   logic [CW-1:0]      cnt_ff, cnt_in, pass_ff, pass_in, issue_ff, issue_in;
   logic               issue_done_ff, issue_done_in, cmp_vld_ff, cmp_vld_in;
   logic [AW-1:0]      cmp_idx_ff, cmp_idx_in;
   logic               has_lb_ff, has_lb_in, best_vld_ff, best_vld_in;
   logic [KW-1:0]      lb_ff, lb_in, best_key_ff, best_key_in;
   logic [OFF_W-1:0]   best_off_ff, best_off_in;
   logic signed [SW-1:0] sum_ff, sum_in;
   logic [RTT_W-1:0]   minrtt_ff, minrtt_in;
   logic               neg_ff, neg_in;
   logic [SW-1:0]      quo_ff, quo_in;
   logic [CW-1:0]      rem_ff, rem_in;
   logic [DCW-1:0]     div_cnt_ff, div_cnt_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_acc_ff, rsp_acc_in, rsp_rdy_ff, rsp_rdy_in;
   logic [CW-1:0]      rsp_cnt_ff, rsp_cnt_in;
   logic [RTT_W-1:0]   rsp_min_ff, rsp_min_in;
   logic [OFF_W-1:0]   rsp_avg_ff, rsp_avg_in;
   logic [TIME_W-1:0]  rsp_loc_ff, rsp_loc_in;
   logic               rsp_lv_ff, rsp_lv_in;

   logic [RTT_W-1:0]   rtt_mem [WINDOW_DEPTH];
   logic [OFF_W-1:0]   off_mem [WINDOW_DEPTH];
   logic [RTT_W-1:0]   rtt_rd_ff;
   logic [OFF_W-1:0]   off_rd_ff;
   logic               wr_en;
   logic [RTT_W-1:0]   rtt_wr;
   logic [OFF_W-1:0]   off_wr;

   logic               start_scan, pass_ok;
   logic [OFF_W:0]     off_diff;
   logic [AW-1:0]      age_start, age;
   logic [AW:0]        age_wide;
   logic [KW-1:0]      key;
   logic [CFG_W-1:0]   bc_eff;
   logic [CW:0]        trial;
   logic [OFF_W-1:0]   qv, mv, hv, q_half;
   logic [OFF_W:0]     sum_loc, diff_loc;

   assign req_bus.ready = (state_ff == ST_IDLE);

   assign rsp_bus.valid              = rsp_valid_ff;
   assign rsp_bus.accepted           = rsp_acc_ff;
   assign rsp_bus.ready_res          = rsp_rdy_ff;
   assign rsp_bus.sample_count       = rsp_cnt_ff;
   assign rsp_bus.min_round_trip     = rsp_min_ff;
   assign rsp_bus.avg_offset_half_ns = rsp_avg_ff;
   assign rsp_bus.local_time         = rsp_loc_ff;
   assign rsp_bus.local_valid        = rsp_lv_ff;

   // The oldest entry sits at the write pointer once the ring has wrapped.
   assign age_start = (fill_ff == DEPTH_C) ? wp_ff : '0;
   assign age_wide  = (cmp_idx_ff >= age_start) ?
                      ({1'b0, cmp_idx_ff} - {1'b0, age_start}) :
                      ({1'b0, cmp_idx_ff} + DEPTH_A - {1'b0, age_start});
   assign age = age_wide[AW-1:0];
   assign key = {rtt_rd_ff, age};
   assign bc_eff = (best_count_ff == '0) ? CFG_W'(1) : best_count_ff;

   always_comb begin
      state_in      = state_ff;
      best_count_in = csr_write_en ? csr_write_data : best_count_ff;
      t0_in = t0_ff; t1_in = t1_ff; t2_in = t2_ff; t3_in = t3_ff; rt_in = rt_ff;
      d30_in = d30_ff; d21_in = d21_ff; a_in = a_ff; b_in = b_ff; nz_in = nz_ff;
      wp_in = wp_ff; fill_in = fill_ff; accepted_in = accepted_ff; op_in = op_ff;
      cnt_in = cnt_ff; pass_in = pass_ff; issue_in = issue_ff;
      issue_done_in = issue_done_ff; cmp_vld_in = 1'b0; cmp_idx_in = issue_ff[AW-1:0];
      has_lb_in = has_lb_ff; lb_in = lb_ff;
      best_vld_in = best_vld_ff; best_key_in = best_key_ff; best_off_in = best_off_ff;
      sum_in = sum_ff; minrtt_in = minrtt_ff; neg_in = neg_ff;
      quo_in = quo_ff; rem_in = rem_ff; div_cnt_in = div_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_acc_in = rsp_acc_ff; rsp_rdy_in = rsp_rdy_ff; rsp_cnt_in = rsp_cnt_ff;
      rsp_min_in = rsp_min_ff; rsp_avg_in = rsp_avg_ff; rsp_loc_in = rsp_loc_ff;
      rsp_lv_in = rsp_lv_ff;
      wr_en = 1'b0;
      start_scan = 1'b0;
      pass_ok = nz_ff && !d30_ff[OFF_W-1] && !d21_ff[OFF_W-1] && (d30_ff >= d21_ff);
      rtt_wr = RTT_W'(d30_ff - d21_ff);
      off_diff = {1'b0, a_ff} - {1'b0, b_ff};
      // Saturate the 65-bit signed difference into 64 bits.
      if (off_diff[OFF_W] == off_diff[OFF_W-1]) begin
         off_wr = off_diff[OFF_W-1:0];
      end else if (off_diff[OFF_W]) begin
         off_wr = {1'b1, {(OFF_W-1){1'b0}}};
      end else begin
         off_wr = {1'b0, {(OFF_W-1){1'b1}}};
      end
      trial = {rem_ff, quo_ff[SW-1]};
      qv = quo_ff[OFF_W-1:0];
      mv = qv + OFF_W'(rem_ff != '0);
      hv = (mv >> 1) + OFF_W'(mv[0]);
      q_half = qv >> 1;
      sum_loc  = {2'b00, rt_ff} + {1'b0, q_half};
      diff_loc = {2'b00, rt_ff} - {1'b0, hv};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               t0_in = req_bus.stamp_send;
               t1_in = req_bus.stamp_remote_recv;
               t2_in = req_bus.stamp_remote_send;
               t3_in = req_bus.stamp_recv;
               rt_in = req_bus.remote_time;
               op_in = req_bus.opcode;
               accepted_in = 1'b0;
               if (req_bus.opcode == OP_EXCHANGE) begin
                  state_in = ST_CHECK;
               end else if (fill_ff == '0) begin
                  state_in = ST_FINISH;
               end else begin
                  start_scan = 1'b1;
               end
            end
         end
         ST_CHECK: begin
            d30_in = {1'b0, t3_ff} - {1'b0, t0_ff};
            d21_in = {1'b0, t2_ff} - {1'b0, t1_ff};
            a_in   = {1'b0, t1_ff} + {1'b0, t2_ff};
            b_in   = {1'b0, t0_ff} + {1'b0, t3_ff};
            nz_in  = (t0_ff != '0) && (t1_ff != '0) && (t2_ff != '0) && (t3_ff != '0);
            state_in = ST_STORE;
         end
         ST_STORE: begin
            if (pass_ok) begin
               wr_en = 1'b1;
               wp_in = (wp_ff == AW'(WINDOW_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
               if (fill_ff != DEPTH_C) fill_in = fill_ff + 1'b1;
               accepted_in = 1'b1;
            end
            if (fill_in == '0) begin
               state_in = ST_FINISH;
            end else begin
               start_scan = 1'b1;
            end
         end
         ST_SCAN: begin
            if (!issue_done_ff) begin
               cmp_vld_in = 1'b1;
               issue_in = issue_ff + 1'b1;
               if (issue_ff == fill_ff - 1'b1) issue_done_in = 1'b1;
            end
            if (cmp_vld_ff && (!has_lb_ff || key > lb_ff) &&
                (!best_vld_ff || key < best_key_ff)) begin
               best_vld_in = 1'b1;
               best_key_in = key;
               best_off_in = off_rd_ff;
            end
            if (issue_done_ff && !cmp_vld_ff) state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            sum_in = sum_ff + SW'(signed'(best_off_ff));
            lb_in = best_key_ff;
            has_lb_in = 1'b1;
            if (pass_ff == '0) minrtt_in = best_key_ff[KW-1:AW];
            if (pass_ff == cnt_ff - 1'b1) begin
               state_in = ST_NORM;
            end else begin
               pass_in = pass_ff + 1'b1;
               issue_in = '0;
               issue_done_in = 1'b0;
               best_vld_in = 1'b0;
               state_in = ST_SCAN;
            end
         end
         ST_NORM: begin
            neg_in = sum_ff[SW-1];
            quo_in = sum_ff[SW-1] ? SW'(-sum_ff) : SW'(sum_ff);
            rem_in = '0;
            div_cnt_in = DCW'(SW);
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            // Restoring division by the number of selected samples, one quotient bit a cycle.
            if (trial >= {1'b0, cnt_ff}) begin
               rem_in = CW'(trial - {1'b0, cnt_ff});
               quo_in = {quo_ff[SW-2:0], 1'b1};
            end else begin
               rem_in = trial[CW-1:0];
               quo_in = {quo_ff[SW-2:0], 1'b0};
            end
            div_cnt_in = div_cnt_ff - 1'b1;
            if (div_cnt_ff == DCW'(1)) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_acc_in = accepted_ff;
               rsp_cnt_in = fill_ff;
               rsp_rdy_in = (fill_ff != '0);
               rsp_min_in = '0;
               rsp_avg_in = '0;
               rsp_loc_in = '0;
               rsp_lv_in = 1'b0;
               if (fill_ff != '0) begin
                  rsp_min_in = minrtt_ff;
                  rsp_avg_in = neg_ff ? (~qv + 1'b1) : qv;
                  if (op_ff == OP_CONVERT) begin
                     if (neg_ff) begin
                        rsp_loc_in = sum_loc[TIME_W-1:0];
                        rsp_lv_in = 1'b1;
                     end else if (!diff_loc[OFF_W]) begin
                        rsp_loc_in = diff_loc[TIME_W-1:0];
                        rsp_lv_in = 1'b1;
                     end
                  end
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (start_scan) begin
         pass_in = '0;
         has_lb_in = 1'b0;
         sum_in = '0;
         issue_in = '0;
         issue_done_in = 1'b0;
         best_vld_in = 1'b0;
         cnt_in = (MW'(bc_eff) > MW'(fill_in)) ? fill_in : CW'(bc_eff);
         state_in = ST_SCAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         best_count_ff <= BEST_COUNT_RESET;
         wp_ff         <= '0;
         fill_ff       <= '0;
         cmp_vld_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         best_count_ff <= best_count_in;
         wp_ff         <= wp_in;
         fill_ff       <= fill_in;
         cmp_vld_ff    <= cmp_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      t0_ff <= t0_in; t1_ff <= t1_in; t2_ff <= t2_in; t3_ff <= t3_in; rt_ff <= rt_in;
      d30_ff <= d30_in; d21_ff <= d21_in; a_ff <= a_in; b_ff <= b_in; nz_ff <= nz_in;
      accepted_ff <= accepted_in; op_ff <= op_in;
      cnt_ff <= cnt_in; pass_ff <= pass_in; issue_ff <= issue_in;
      issue_done_ff <= issue_done_in; cmp_idx_ff <= cmp_idx_in;
      has_lb_ff <= has_lb_in; lb_ff <= lb_in;
      best_vld_ff <= best_vld_in; best_key_ff <= best_key_in; best_off_ff <= best_off_in;
      sum_ff <= sum_in; minrtt_ff <= minrtt_in; neg_ff <= neg_in;
      quo_ff <= quo_in; rem_ff <= rem_in; div_cnt_ff <= div_cnt_in;
      rsp_acc_ff <= rsp_acc_in; rsp_rdy_ff <= rsp_rdy_in; rsp_cnt_ff <= rsp_cnt_in;
      rsp_min_ff <= rsp_min_in; rsp_avg_ff <= rsp_avg_in; rsp_loc_ff <= rsp_loc_in;
      rsp_lv_ff <= rsp_lv_in;
   end

   // Sample window: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         rtt_mem[wp_ff] <= rtt_wr;
         off_mem[wp_ff] <= off_wr;
      end
      rtt_rd_ff <= rtt_mem[issue_ff[AW-1:0]];
      off_rd_ff <= off_mem[issue_ff[AW-1:0]];
   end

endmodule
